// ----- rtl/sfd_pkg.sv -----
// Package for the sync framed serial deframer.
// Holds the byte tags, the queue entry type and the register indexes.
// No dependencies.
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int BYTE_W     = 8;
    localparam int ID_W       = 16;
    localparam int PAYLOAD_W  = 64;
    localparam int SLOT_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int TAG_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'd1;

    localparam logic [TAG_W-1:0] TAG_ID_HI = 3'd0;
    localparam logic [TAG_W-1:0] TAG_ID_LO = 3'd1;
    localparam logic [TAG_W-1:0] TAG_DATA  = 3'd2;
    localparam logic [TAG_W-1:0] TAG_COUNT = 3'd3;
    localparam logic [TAG_W-1:0] TAG_CHECK = 3'd4;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd85;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd14;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] data;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

endpackage

// ----- rtl/sfd_front.sv -----
// Front end of the deframer: sync hunt, phase tracking, byte tagging.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_front
    import sfd_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_wdata,
    input  logic                 i_accept,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output t_push                o_push
);

    localparam int IDX_W = $clog2(PAYLOAD_BYTES + 1);

    localparam logic [2:0] PH_SYNC1 = 3'd0;
    localparam logic [2:0] PH_SYNC2 = 3'd1;
    localparam logic [2:0] PH_IDHI  = 3'd2;
    localparam logic [2:0] PH_IDLO  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CHECK = 3'd5;

    logic [BYTE_W-1:0] r_sync_first;
    logic [BYTE_W-1:0] r_sync_second;
    logic [2:0]        r_phase;
    logic [2:0]        n_phase;
    logic [IDX_W-1:0]  r_index;
    logic [IDX_W-1:0]  n_index;
    t_push             w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_wdata;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase           = r_phase;
        n_index           = r_index;
        w_push.push       = 1'b0;
        w_push.entry.tag  = TAG_DATA;
        w_push.entry.slot = SLOT_W'(r_index);
        w_push.entry.data = i_rx_byte;
        case (r_phase)
            PH_SYNC2: begin
                n_phase = (i_rx_byte == r_sync_second) ? PH_IDHI : PH_SYNC1;
            end
            PH_IDHI: begin
                w_push.push      = 1'b1;
                w_push.entry.tag = TAG_ID_HI;
                n_phase          = PH_IDLO;
            end
            PH_IDLO: begin
                w_push.push      = 1'b1;
                w_push.entry.tag = TAG_ID_LO;
                n_index          = '0;
                n_phase          = PH_DATA;
            end
            PH_DATA: begin
                w_push.push = 1'b1;
                if (r_index < IDX_W'(PAYLOAD_BYTES)) begin
                    w_push.entry.tag = TAG_DATA;
                    n_index          = IDX_W'(r_index + 1'b1);
                end else begin
                    w_push.entry.tag = TAG_COUNT;
                    n_index          = '0;
                    n_phase          = PH_CHECK;
                end
            end
            PH_CHECK: begin
                w_push.push      = 1'b1;
                w_push.entry.tag = TAG_CHECK;
                n_phase          = PH_SYNC1;
            end
            default: begin
                n_phase = (i_rx_byte == r_sync_first) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_index <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_index <= n_index;
        end
    end

    always_comb begin
        o_push      = w_push;
        o_push.push = w_push.push & i_accept;
    end

endmodule

// ----- rtl/sfd_queue.sv -----
// Two-entry queue of tagged bytes between front and back end.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_queue
    import sfd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_head
);

    t_entry     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push.push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/sfd_back.sv -----
// Back end of the deframer: frame assembly, payload sum, output register.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_back
    import sfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  t_entry               i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ID_W-1:0]      o_msg_id,
    output logic [PAYLOAD_W-1:0] o_payload,
    output logic [BYTE_W-1:0]    o_count_byte,
    output logic [BYTE_W-1:0]    o_check_byte,
    output logic [BYTE_W-1:0]    o_payload_sum
);

    logic [ID_W-1:0]      r_id;
    logic [PAYLOAD_W-1:0] r_payload;
    logic [BYTE_W-1:0]    r_sum;
    logic [BYTE_W-1:0]    r_count;
    logic                 r_out_valid;
    logic [ID_W-1:0]      r_out_id;
    logic [PAYLOAD_W-1:0] r_out_payload;
    logic [BYTE_W-1:0]    r_out_count;
    logic [BYTE_W-1:0]    r_out_check;
    logic [BYTE_W-1:0]    r_out_sum;
    logic                 w_out_free;
    logic                 w_emit;

    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign o_pop      = ~i_empty & ((i_head.tag != TAG_CHECK) | w_out_free);
    assign w_emit     = o_pop & (i_head.tag == TAG_CHECK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id      <= '0;
            r_payload <= '0;
            r_sum     <= '0;
            r_count   <= '0;
        end else if (o_pop) begin
            case (i_head.tag)
                TAG_ID_HI: r_id <= {i_head.data, {BYTE_W{1'b0}}};
                TAG_ID_LO: r_id <= r_id | {{(ID_W-BYTE_W){1'b0}}, i_head.data};
                TAG_DATA: begin
                    r_payload[i_head.slot*BYTE_W +: BYTE_W] <= i_head.data;
                    r_sum <= r_sum + i_head.data;
                end
                TAG_COUNT: r_count <= i_head.data;
                TAG_CHECK: begin
                    r_payload <= '0;
                    r_sum     <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_id      <= r_id;
            r_out_payload <= r_payload;
            r_out_count   <= r_count;
            r_out_check   <= i_head.data;
            r_out_sum     <= r_sum;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_msg_id      = r_out_id;
    assign o_payload     = r_out_payload;
    assign o_count_byte  = r_out_count;
    assign o_check_byte  = r_out_check;
    assign o_payload_sum = r_out_sum;

endmodule

// ----- rtl/sync_framed_serial_deframer.sv -----
// Top level of the sync framed serial deframer.
// Depends on sfd_pkg, sfd_front, sfd_queue and sfd_back.
//
// Takes one serial byte per transaction, one per clock while the input is not stalled, and
// emits one frame per completed frame: two sync bytes, a 16-bit identifier
// (high byte first), PAYLOAD_BYTES payload bytes, a count byte and a check
// byte. The received check byte and the computed payload sum mod 256 are
// both passed out; nothing is compared. The front end tags each frame byte
// after the sync pair and pushes it into a two-entry queue; the back end
// assembles the frame. A frame appears at the output once its check byte
// has passed through the queue register and been popped while the output
// register is free; the output register then loads it. Input stalls only
// when the queue is full, which happens when the output is held stalled.
`timescale 1ns / 1ps

module sync_framed_serial_deframer
    import sfd_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ID_W-1:0]      o_msg_id,
    output logic [PAYLOAD_W-1:0] o_payload,
    output logic [BYTE_W-1:0]    o_count_byte,
    output logic [BYTE_W-1:0]    o_check_byte,
    output logic [BYTE_W-1:0]    o_payload_sum
);

    t_push  w_push;
    t_entry w_head;
    logic   w_full;
    logic   w_empty;
    logic   w_pop;
    logic   w_accept;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid & ~w_full;

    sfd_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx_byte),
        .o_push      (w_push)
    );

    sfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    sfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_msg_id      (o_msg_id),
        .o_payload     (o_payload),
        .o_count_byte  (o_count_byte),
        .o_check_byte  (o_check_byte),
        .o_payload_sum (o_payload_sum)
    );

endmodule

// ----- bench/sync_framed_serial_deframer_tb.sv -----
// Self-checking bench for sync_framed_serial_deframer: random sync-framed byte streams
// with gaps and output stalls, checked against an in-bench frame parser.
// Depends on sfd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module sync_framed_serial_deframer_tb
    import sfd_pkg::*;
;

    localparam int PAYLOAD_BYTES   = 8;
    localparam int RST_CYCLES      = 10;
    localparam int SETTLE_CYCLES   = 8;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int PRESSURE_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 10;

    typedef enum logic [2:0] {
        PH_HUNT, PH_SYNC2, PH_ID_HI, PH_ID_LO, PH_DATA, PH_CHECK
    } t_parse_phase;

    typedef struct {
        logic [ID_W-1:0]      msg_id;
        logic [PAYLOAD_W-1:0] payload;
        logic [BYTE_W-1:0]    count_byte;
        logic [BYTE_W-1:0]    check_byte;
        logic [BYTE_W-1:0]    payload_sum;
    } t_frame;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_SYNC_FIRST;
    logic [BYTE_W-1:0]    i_cfg_wdata = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_rx_byte   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [ID_W-1:0]      o_msg_id;
    logic [PAYLOAD_W-1:0] o_payload;
    logic [BYTE_W-1:0]    o_count_byte;
    logic [BYTE_W-1:0]    o_check_byte;
    logic [BYTE_W-1:0]    o_payload_sum;

    // parser model state and its copy of the sync registers
    t_parse_phase         mdl_phase   = PH_HUNT;
    logic [ID_W-1:0]      mdl_id      = '0;
    logic [PAYLOAD_W-1:0] mdl_payload = '0;
    logic [3:0]           mdl_index   = '0;
    logic [BYTE_W-1:0]    mdl_sum     = '0;
    logic [BYTE_W-1:0]    mdl_count   = '0;
    logic [BYTE_W-1:0]    mdl_sync_first  = SYNC_FIRST_RST;
    logic [BYTE_W-1:0]    mdl_sync_second = SYNC_SECOND_RST;

    logic [BYTE_W-1:0] rx_backlog[$];
    t_frame            frames_due[$];

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned src_gap      = 0;
    int unsigned snk_hold     = 0;
    bit          pressure_arm = 1'b0;
    bit          saw_in_stall = 1'b0;
    int unsigned cycles       = 0;
    int unsigned mismatches   = 0;
    int unsigned bytes_sent   = 0;
    int unsigned frames_seen  = 0;
    int unsigned settings_run = 0;

    sync_framed_serial_deframer #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_msg_id     (o_msg_id),
        .o_payload    (o_payload),
        .o_count_byte (o_count_byte),
        .o_check_byte (o_check_byte),
        .o_payload_sum(o_payload_sum)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned idle_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return 8'h00;
        end else if (pick == 1) begin
            return 8'hFF;
        end
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        t_frame f;
        case (mdl_phase)
            PH_SYNC2: mdl_phase = (b == mdl_sync_second) ? PH_ID_HI : PH_HUNT;
            PH_ID_HI: begin
                mdl_id    = {b, 8'h00};
                mdl_phase = PH_ID_LO;
            end
            PH_ID_LO: begin
                mdl_id[7:0] = b;
                mdl_index   = '0;
                mdl_phase   = PH_DATA;
            end
            PH_DATA: begin
                if (mdl_index < PAYLOAD_BYTES) begin
                    mdl_payload[8*mdl_index +: 8] = b;
                    mdl_sum   = mdl_sum + b;
                    mdl_index = mdl_index + 1'b1;
                end else begin
                    mdl_count = b;
                    mdl_index = '0;
                    mdl_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                f.msg_id      = mdl_id;
                f.payload     = mdl_payload;
                f.count_byte  = mdl_count;
                f.check_byte  = b;
                f.payload_sum = mdl_sum;
                frames_due.push_back(f);
                mdl_sum     = '0;
                mdl_payload = '0;
                mdl_phase   = PH_HUNT;
            end
            default: mdl_phase = (b == mdl_sync_first) ? PH_SYNC2 : PH_HUNT;
        endcase
    endtask

    // driver: offer backlog bytes, hold payload while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_stall) begin
                saw_in_stall = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                deframe_byte(i_rx_byte);
                bytes_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_in_valid <= 1'b0;
                end else if (rx_backlog.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_rx_byte  <= rx_backlog.pop_front();
                    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
                        src_gap = idle_len();
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [PAYLOAD_W-1:0] exp_val,
                               input logic [PAYLOAD_W-1:0] act_val);
        if (exp_val !== act_val) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("mismatch frame %0d %s: expected %h, got %h",
                         frames_seen, name, exp_val, act_val);
            end
        end
    endtask

    // monitor: compare frames, drive random and long output stalls
    always @(posedge i_clk) begin
        t_frame f;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (frames_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected frame: id %h payload %h", o_msg_id, o_payload);
                    end
                end else begin
                    f = frames_due.pop_front();
                    check_field("msg_id", PAYLOAD_W'(f.msg_id), PAYLOAD_W'(o_msg_id));
                    check_field("payload", f.payload, o_payload);
                    check_field("count_byte", PAYLOAD_W'(f.count_byte),
                                PAYLOAD_W'(o_count_byte));
                    check_field("check_byte", PAYLOAD_W'(f.check_byte),
                                PAYLOAD_W'(o_check_byte));
                    check_field("payload_sum", PAYLOAD_W'(f.payload_sum),
                                PAYLOAD_W'(o_payload_sum));
                end
                frames_seen++;
            end
            if (pressure_arm) begin
                snk_hold     = PRESSURE_CYCLES;
                pressure_arm = 1'b0;
            end
            if (snk_hold > 0) begin
                snk_hold--;
                i_out_stall <= 1'b1;
            end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
                snk_hold = idle_len() - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d frames outstanding",
                     cycles, frames_due.size());
            $display("FAIL sync_framed_serial_deframer");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SYNC_FIRST) begin
            mdl_sync_first = val;
        end else begin
            mdl_sync_second = val;
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (rx_backlog.size() != 0 || i_in_valid || frames_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic push_frame(inout int unsigned n);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        sum = '0;
        rx_backlog.push_back(mdl_sync_first);
        rx_backlog.push_back(mdl_sync_second);
        rx_backlog.push_back(rand_byte());
        rx_backlog.push_back(rand_byte());
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            b   = rand_byte();
            sum = sum + b;
            rx_backlog.push_back(b);
        end
        rx_backlog.push_back(rand_byte());
        rx_backlog.push_back($urandom_range(0, 1) ? sum : rand_byte());
        n += PAYLOAD_BYTES + 6;
    endtask

    task automatic run_phase(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
                             input int unsigned src_pct, input int unsigned snk_pct,
                             input bit pressure);
        int unsigned n;
        int unsigned pick;
        int unsigned extra;
        write_reg(CFG_SYNC_FIRST, s1);
        write_reg(CFG_SYNC_SECOND, s2);
        settings_run++;
        @(negedge i_clk);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        pressure_arm = pressure;
        n = 0;
        while (n < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                push_frame(n);
            end else if (pick < 85) begin
                // broken sync: first byte then a wrong second byte
                rx_backlog.push_back(mdl_sync_first);
                rx_backlog.push_back(mdl_sync_second ^ BYTE_W'($urandom_range(1, 255)));
                n += 2;
            end else if (pick < 90) begin
                rx_backlog.push_back(mdl_sync_first);
                rx_backlog.push_back(mdl_sync_first);
                rx_backlog.push_back(mdl_sync_second);
                n += 3;
            end else begin
                extra = $urandom_range(1, 5);
                repeat (extra) rx_backlog.push_back(BYTE_W'($urandom_range(0, 255)));
                n += extra;
            end
        end
        drain();
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // full-range frame, then a wrong second sync byte followed by the second sync value
        rx_backlog = '{SYNC_FIRST_RST, SYNC_SECOND_RST, 8'hFF, 8'h00,
                       8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF,
                       8'h00, 8'hFF,
                       SYNC_FIRST_RST, SYNC_FIRST_RST, SYNC_SECOND_RST, 8'h07};
        drain();

        run_phase(SYNC_FIRST_RST, SYNC_SECOND_RST, 0, 30, 1'b1);
        run_phase(8'h00, 8'hFF, 30, 30, 1'b0);
        run_phase(8'hFF, 8'h00, 0, 0, 1'b0);
        run_phase(8'hAA, 8'hAA, 50, 10, 1'b0);
        run_phase(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                  20, 50, 1'b0);

        drain();
        $display("Sent %0d bytes, checked %0d frames over %0d sync settings.",
                 bytes_sent, frames_seen, settings_run);
        $display("Long output hold-off %s input stall.",
                 saw_in_stall ? "reached" : "did not reach");
        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("PASS sync_framed_serial_deframer");
        end else begin
            $display("%0d mismatches, %0d frames never arrived", mismatches, frames_due.size());
            $display("FAIL sync_framed_serial_deframer");
        end
        $finish;
    end

endmodule
